// ----- rtl/oale_pkg.sv -----
// ----------------------------------------------------------------------------
// Ordered array list engine package
// Item types, command and status codes, and sizing constants shared by the
// list engine and its word store.
// ----------------------------------------------------------------------------
package oale_pkg;

  // Default number of slots in the word store.
  localparam int OALE_DEPTH = 16;

  // Field widths fixed by the item format.
  localparam int CMD_W    = 3;
  localparam int IDX_W    = 4;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Command codes. Codes five to seven are unused and change nothing.
  localparam logic [CMD_W-1:0] CMD_APPEND    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_OVERWRITE = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADINDEX  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd3;

  // Word written into the slot a delete vacates and returned when there is nothing to read.
  localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic [IDX_W-1:0]         index;
    logic signed [WORD_W-1:0] value;
  } oale_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] read_value;
    logic [COUNT_W-1:0]       element_count;
  } oale_out_t;

endpackage

// ----- rtl/oale_ram.sv -----
// ----------------------------------------------------------------------------
// Ordered array list word store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module oale_ram #(
  parameter int DEPTH = oale_pkg::OALE_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [AW-1:0]                      wr_addr,
  input  logic signed [oale_pkg::WORD_W-1:0] wr_data,
  input  logic                               rd_en,
  input  logic [AW-1:0]                      rd_addr,
  output logic signed [oale_pkg::WORD_W-1:0] rd_data
);
  import oale_pkg::*;

  logic signed [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/ordered_array_list_engine.sv -----
// An error or unknown command goes straight to the response step; append and overwrite
// use the final write step, read a read and a move step, insert and delete a read and a
// move step per shifted slot and then the final write step; the port is ready again as the
// result is raised, later only while an earlier result is still held by the receiver.
// Items are taken one at a time; a shift moves one slot per read and move step over the
// store port. Reset clears the fill count to zero and sets the capacity register to 16;
// the store is not cleared, since no slot at or above the fill count is ever read.
// ----------------------------------------------------------------------------
// Ordered array list engine
// Keeps a packed list of signed words with append, insert, delete, read and
// overwrite commands, one result item per command.
// ----------------------------------------------------------------------------
module ordered_array_list_engine #(
  parameter int DEPTH = oale_pkg::OALE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Command items.
  input  logic                               in_valid,
  output logic                               in_ready,
  input  oale_pkg::oale_in_t                 in_data,
  // Result items.
  output logic                               out_valid,
  input  logic                               out_ready,
  output oale_pkg::oale_out_t                out_data,
  // Capacity register write.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [oale_pkg::COUNT_W-1:0]       cfg_data
);
  import oale_pkg::*;

  // The store address covers DEPTH slots. The fill count only grows while it
  // is below the usable capacity, which is the capacity register limited to
  // DEPTH and to what five bits can count.
  localparam int AW = $clog2(DEPTH);
  localparam int CAP_LIM = (DEPTH > 31) ? 31 : DEPTH;
  localparam logic [COUNT_W-1:0] CAP_MAX = COUNT_W'(CAP_LIM);

  // The sequencer. Every command is checked on the cycle it is taken. A read or a
  // shift step reads one slot, then the move step returns what came back (read) or
  // writes it one slot up (insert) or down (delete). The last step writes the new
  // word (append, insert, overwrite) or the empty word (delete) and updates the count.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_MOVE = 5'b00100,
    S_LAST = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  state_t                   state_r,  state_nxt;
  logic [COUNT_W-1:0]       fill_r,   fill_nxt;
  logic [COUNT_W-1:0]       cap_r;
  logic [COUNT_W-1:0]       ptr_r,    ptr_nxt;
  logic [CMD_W-1:0]         cmd_r,    cmd_nxt;
  logic [IDX_W-1:0]         idx_r,    idx_nxt;
  logic signed [WORD_W-1:0] ldata_r,  ldata_nxt;
  logic [STATUS_W-1:0]      status_r, status_nxt;
  logic signed [WORD_W-1:0] rdval_r,  rdval_nxt;
  logic                     out_valid_r, out_valid_nxt;
  oale_out_t                out_data_r,  out_data_nxt;

  logic [COUNT_W-1:0]       cap_use;
  logic [COUNT_W-1:0]       idx_x;
  logic [COUNT_W-1:0]       fill_inc;
  logic [COUNT_W-1:0]       fill_dec;
  logic [COUNT_W-1:0]       neighbor;
  logic                     shifting;

  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic signed [WORD_W-1:0] wr_data;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic signed [WORD_W-1:0] rd_data;

  oale_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A capacity above what the store holds acts as the full store.
  assign cap_use  = (cap_r > CAP_MAX) ? CAP_MAX : cap_r;
  assign idx_x    = {1'b0, in_data.index};
  assign fill_inc = fill_r + 5'd1;
  assign fill_dec = fill_r - 5'd1;

  // The shared step unit: the slot next to the pointer in the direction of
  // the shift. Insert walks down from the top, delete walks up from the index.
  assign shifting = (cmd_r == CMD_INSERT) || (cmd_r == CMD_DELETE);
  assign neighbor = ptr_r + ((cmd_r == CMD_INSERT) ? 5'h1F : 5'h01);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    ptr_nxt       = ptr_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    ldata_nxt     = ldata_r;
    status_nxt    = status_r;
    rdval_nxt     = rdval_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = AW'(ptr_r);
    wr_data       = ldata_r;
    rd_en         = 1'b0;
    rd_addr       = shifting ? AW'(neighbor) : AW'(ptr_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_data.command;
          idx_nxt    = in_data.index;
          ldata_nxt  = in_data.value;
          status_nxt = ST_OK;
          rdval_nxt  = EMPTY_WORD;
          state_nxt  = S_RESP;
          case (in_data.command)
            CMD_APPEND: begin
              if (fill_r >= cap_use) begin
                status_nxt = ST_OVERFLOW;
              end else begin
                ptr_nxt   = fill_r;
                state_nxt = S_LAST;
              end
            end
            CMD_INSERT: begin
              // The index is checked before the room.
              if (idx_x > fill_r) begin
                status_nxt = ST_BADINDEX;
              end else if (fill_r >= cap_use) begin
                status_nxt = ST_OVERFLOW;
              end else begin
                ptr_nxt   = fill_r;
                state_nxt = (idx_x == fill_r) ? S_LAST : S_READ;
              end
            end
            CMD_DELETE: begin
              // An empty list is reported before a bad index.
              if (fill_r == 5'd0) begin
                status_nxt = ST_UNDERFLOW;
              end else if (idx_x >= fill_r) begin
                status_nxt = ST_BADINDEX;
              end else begin
                ptr_nxt   = idx_x;
                ldata_nxt = EMPTY_WORD;
                state_nxt = (idx_x == fill_dec) ? S_LAST : S_READ;
              end
            end
            CMD_READ: begin
              if (idx_x >= fill_r) begin
                status_nxt = ST_BADINDEX;
              end else begin
                ptr_nxt   = idx_x;
                state_nxt = S_READ;
              end
            end
            CMD_OVERWRITE: begin
              if (idx_x >= fill_r) begin
                status_nxt = ST_BADINDEX;
              end else begin
                ptr_nxt   = idx_x;
                state_nxt = S_LAST;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_READ: begin
        rd_en     = 1'b1;
        state_nxt = S_MOVE;
      end
      S_MOVE: begin
        if (cmd_r == CMD_READ) begin
          rdval_nxt = rd_data;
          state_nxt = S_RESP;
        end else begin
          wr_en   = 1'b1;
          wr_data = rd_data;
          ptr_nxt = neighbor;
          if ((cmd_r == CMD_INSERT) ? (neighbor == {1'b0, idx_r}) : (neighbor == fill_dec)) begin
            state_nxt = S_LAST;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_LAST: begin
        wr_en = 1'b1;
        case (cmd_r) inside
          CMD_APPEND, CMD_INSERT: fill_nxt = fill_inc;
          CMD_DELETE:             fill_nxt = fill_dec;
          default:                fill_nxt = fill_r;
        endcase
        state_nxt = S_RESP;
      end
      S_RESP: begin
        // Wait here only while the previous result has not been taken.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = status_r;
          out_data_nxt.read_value    = rdval_r;
          out_data_nxt.element_count = fill_r;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      cap_r       <= 5'd16;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
    end
  end

  // Working registers of the current item and the result register.
  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    cmd_r      <= cmd_nxt;
    idx_r      <= idx_nxt;
    ldata_r    <= ldata_nxt;
    status_r   <= status_nxt;
    rdval_r    <= rdval_nxt;
    out_data_r <= out_data_nxt;
  end

  // The fill count never passes the usable limit of the store.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CAP_MAX)
    else $error("fill count above store limit");

  // The fill count only moves on the final write step of a command.
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(fill_r)) |-> ($past(state_r) == S_LAST))
    else $error("fill count changed outside the final write step");

  // Store accesses of a command stay within the list or the slot just above it.
  a_ptr_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ || state_r == S_MOVE || state_r == S_LAST) |-> (ptr_r <= fill_r))
    else $error("store pointer beyond the list");

  // A taken item blocks the port until its result is produced.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new item taken while one is in progress");

  // A result only appears from the response step.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> ($past(state_r) == S_RESP))
    else $error("result raised outside the response step");

endmodule
